// ----- rtl/core/c2p_pkg.sv -----
`timescale 1ns / 1ps
package c2p_pkg;

	localparam logic [1:0] REG_THERMAL_MODE    = 2'd0;
	localparam logic [1:0] REG_ADIABATIC_INDEX = 2'd1;

	localparam logic        THERMAL_MODE_RESET = 1'b1;
	localparam logic [13:0] GAMMA_RESET        = 14'd5734;
	localparam logic [14:0] GAMMA_ONE          = 15'd4096;
	localparam logic [59:0] KE_CAP             = 60'h800_0000_0000_0000;
	localparam logic [63:0] MAG_HUGE           = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] POS_MAX            = 64'h0000_0000_7FFF_FFFF;
	localparam logic [63:0] NEG_MAG            = 64'h0000_0000_8000_0000;

	typedef struct packed {
		logic [30:0]        density;
		logic signed [31:0] momentum_x;
		logic signed [31:0] momentum_y;
		logic signed [31:0] momentum_z;
		logic signed [31:0] total_energy;
	} cell_word_t;

	typedef struct packed {
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
		logic signed [31:0] heat_value;
		logic               zero_density;
		logic               overflow;
	} prim_word_t;

	typedef struct packed {
		logic [31:0] val;
		logic        ov;
	} clip_t;

	typedef struct packed {
		logic               kcap;
		logic               zero;
		logic [30:0]        rho;
		logic [2:0][31:0]   mag;
		logic [2:0]         neg;
		logic signed [31:0] e;
	} ke_side_t;

	typedef struct packed {
		logic  tsat;
		logic  sgn;
		logic  gzero;
		logic  zero;
		clip_t th;
	} tmp_side_t;

	typedef struct packed {
		logic neg;
		logic sat;
	} vel_side_t;

	function automatic clip_t clip32(input logic neg, input logic [63:0] mag);
		clip_t r;
		r.ov = 1'b0;
		if (neg) begin
			if (mag > NEG_MAG) begin
				r.ov  = 1'b1;
				r.val = 32'h8000_0000;
			end else begin
				r.val = 32'(~mag[31:0] + 32'd1);
			end
		end else begin
			if (mag > POS_MAX) begin
				r.ov  = 1'b1;
				r.val = 32'h7FFF_FFFF;
			end else begin
				r.val = mag[31:0];
			end
		end
		return r;
	endfunction

endpackage

// ----- rtl/core/c2p_div_pipe.sv -----
`timescale 1ns / 1ps
module c2p_div_pipe #(
	parameter int NW = 31,
	parameter int K  = 32,
	parameter int SW = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          enable,
	input  logic          valid,
	input  logic [NW-1:0] dividend_hi,
	input  logic [K-1:0]  dividend_lo,
	input  logic [NW-1:0] divisor,
	input  logic [SW-1:0] side,
	output logic          quo_valid,
	output logic [K-1:0]  quotient,
	output logic [SW-1:0] quo_side
);

	logic [NW-1:0] rem_s  [K+1];
	logic [K-1:0]  lo_s   [K+1];
	logic [NW-1:0] div_s  [K+1];
	logic [SW-1:0] side_s [K+1];
	logic          v_s    [K+1];

	assign rem_s[0]  = dividend_hi;
	assign lo_s[0]   = dividend_lo;
	assign div_s[0]  = divisor;
	assign side_s[0] = side;
	assign v_s[0]    = valid;

	genvar i;
	for (i = 0; i < K; i++) begin : g_step
		logic [NW:0] trial;
		logic [NW:0] diff;
		logic        ge;

		assign trial = {rem_s[i], lo_s[i][K-1]};
		assign ge    = trial >= {1'b0, div_s[i]};
		assign diff  = trial - {1'b0, div_s[i]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (enable) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (enable) begin
				rem_s[i+1]  <= ge ? diff[NW-1:0] : trial[NW-1:0];
				lo_s[i+1]   <= {lo_s[i][K-2:0], ge};
				div_s[i+1]  <= div_s[i];
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign quo_valid = v_s[K];
	assign quotient  = lo_s[K];
	assign quo_side  = side_s[K];

endmodule

// ----- rtl/core/conservative_to_primitive.sv -----
`timescale 1ns / 1ps
// throughput: one word per cycle, no gaps; a stall on prim freezes every stage
// depth set by the 60-step kinetic energy divider and the 32-step output dividers,
// each one restoring step per pipeline stage
// reset clears all valid bits and loads thermal_mode 1, adiabatic_index 5734
module conservative_to_primitive (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cell_valid,
	output logic                cell_ready,
	input  c2p_pkg::cell_word_t cons,
	output logic                prim_valid,
	input  logic                prim_ready,
	output c2p_pkg::prim_word_t prim,
	input  logic                write_en,
	input  logic [1:0]          reg_index,
	input  logic [13:0]         write_data
);

	logic        thermal_q;
	logic [13:0] gamma_q;
	logic        en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thermal_q <= c2p_pkg::THERMAL_MODE_RESET;
			gamma_q   <= c2p_pkg::GAMMA_RESET;
		end else if (write_en) begin
			case (reg_index)
				c2p_pkg::REG_THERMAL_MODE:    thermal_q <= write_data[0];
				c2p_pkg::REG_ADIABATIC_INDEX: gamma_q   <= write_data;
				default: ;
			endcase
		end
	end

	assign en         = !prim_valid || prim_ready;
	assign cell_ready = en;

	// stage 1: sign and magnitude
	logic               v_s1, v_s2, v_s3, v_s4, v_s5;
	logic               v_k;
	logic [30:0]        rho_s1, rho_s2, rho_s3;
	logic [2:0][31:0]   mag_s1, mag_s2, mag_s3;
	logic [2:0]         neg_s1, neg_s2, neg_s3;
	logic signed [31:0] e_s1, e_s2, e_s3;
	logic [2:0][31:0]   mom;
	logic [2:0][63:0]   sq_s2;
	logic [63:0]        sum_s3;

	assign mom[0] = cons.momentum_x;
	assign mom[1] = cons.momentum_y;
	assign mom[2] = cons.momentum_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= cell_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_k;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rho_s1 <= cons.density;
			e_s1   <= cons.total_energy;
			for (int k = 0; k < 3; k++) begin
				neg_s1[k] <= mom[k][31];
				mag_s1[k] <= mom[k][31] ? (~mom[k] + 32'd1) : mom[k];
			end
			rho_s2 <= rho_s1;
			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
			e_s2   <= e_s1;
			for (int k = 0; k < 3; k++) begin
				sq_s2[k] <= {32'd0, mag_s1[k]} * {32'd0, mag_s1[k]};
			end
			rho_s3 <= rho_s2;
			mag_s3 <= mag_s2;
			neg_s3 <= neg_s2;
			e_s3   <= e_s2;
			sum_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
		end
	end

	// kinetic energy divider: sum of squares over twice the density
	logic [31:0]       k_hi, k_div;
	logic              kcap;
	c2p_pkg::ke_side_t k_side, k_side_out;
	logic [59:0]       k_quo;

	assign k_div = {rho_s3, 1'b0};
	assign kcap  = {28'd0, sum_s3[63:60]} >= k_div;
	assign k_hi  = kcap ? 32'd0 : {28'd0, sum_s3[63:60]};

	always_comb begin
		k_side.kcap = kcap;
		k_side.zero = rho_s3 == 31'd0;
		k_side.rho  = rho_s3;
		k_side.mag  = mag_s3;
		k_side.neg  = neg_s3;
		k_side.e    = e_s3;
	end

	c2p_div_pipe #(
		.NW(32),
		.K (60),
		.SW($bits(c2p_pkg::ke_side_t))
	) u_ke_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.enable     (en),
		.valid      (v_s3),
		.dividend_hi(k_hi),
		.dividend_lo(sum_s3[59:0]),
		.divisor    (k_div),
		.side       (k_side),
		.quo_valid  (v_k),
		.quotient   (k_quo),
		.quo_side   (k_side_out)
	);

	// stage 4: thermal energy, stage 5: scale by gamma - 1
	logic [59:0]        ke;
	logic signed [61:0] eth;
	logic [61:0]        eth_neg;
	logic               tneg_s4;
	logic [60:0]        tmag_s4;
	c2p_pkg::ke_side_t  ks_s4, ks_s5;
	logic signed [14:0] g;
	logic [14:0]        g_abs;
	logic [13:0]        gm;
	logic [74:0]        prod_s5;
	c2p_pkg::clip_t     th_s5;
	logic               sgn_s5, gzero_s5;

	assign ke      = (k_side_out.kcap || k_quo > c2p_pkg::KE_CAP) ? c2p_pkg::KE_CAP : k_quo;
	assign eth     = $signed({{30{k_side_out.e[31]}}, k_side_out.e}) - $signed({2'b00, ke});
	assign eth_neg = ~eth + 62'd1;
	assign g       = $signed({1'b0, gamma_q}) - $signed(c2p_pkg::GAMMA_ONE);
	assign g_abs   = g[14] ? (~g + 15'd1) : g;
	assign gm      = g_abs[13:0];

	always_ff @(posedge clk) begin
		if (en) begin
			ks_s4    <= k_side_out;
			tneg_s4  <= eth[61];
			tmag_s4  <= eth[61] ? eth_neg[60:0] : eth[60:0];
			ks_s5    <= ks_s4;
			prod_s5  <= 75'({14'd0, tmag_s4} * {61'd0, gm});
			th_s5    <= c2p_pkg::clip32(tneg_s4, {3'd0, tmag_s4});
			sgn_s5   <= tneg_s4 ^ g[14];
			gzero_s5 <= gm == 14'd0;
		end
	end

	// output dividers
	logic [78:0]        num;
	logic [46:0]        n_hi;
	logic               tsat;
	logic [30:0]        t_hi;
	c2p_pkg::tmp_side_t t_side, t_side_out;
	logic               v_t;
	logic [31:0]        t_quo;

	assign num  = {prod_s5, 4'd0};
	assign n_hi = num[78:32];
	assign tsat = n_hi >= {16'd0, ks_s5.rho};
	assign t_hi = tsat ? 31'd0 : n_hi[30:0];

	always_comb begin
		t_side.tsat  = tsat;
		t_side.sgn   = sgn_s5;
		t_side.gzero = gzero_s5;
		t_side.zero  = ks_s5.zero;
		t_side.th    = th_s5;
	end

	c2p_div_pipe #(
		.NW(31),
		.K (32),
		.SW($bits(c2p_pkg::tmp_side_t))
	) u_temp_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.enable     (en),
		.valid      (v_s5),
		.dividend_hi(t_hi),
		.dividend_lo(num[31:0]),
		.divisor    (ks_s5.rho),
		.side       (t_side),
		.quo_valid  (v_t),
		.quotient   (t_quo),
		.quo_side   (t_side_out)
	);

	logic [2:0]         v_vel;
	logic [2:0][31:0]   v_quo;
	c2p_pkg::vel_side_t v_side     [3];
	c2p_pkg::vel_side_t v_side_out [3];
	logic [2:0][30:0]   v_hi;
	logic [2:0][30:0]   v_raw;

	genvar j;
	for (j = 0; j < 3; j++) begin : g_vel
		assign v_raw[j]      = {15'd0, ks_s5.mag[j][31:16]};
		assign v_side[j].sat = v_raw[j] >= ks_s5.rho;
		assign v_side[j].neg = ks_s5.neg[j];
		assign v_hi[j]       = v_side[j].sat ? 31'd0 : v_raw[j];

		c2p_div_pipe #(
			.NW(31),
			.K (32),
			.SW($bits(c2p_pkg::vel_side_t))
		) u_vel_div (
			.clk        (clk),
			.arst_n     (arst_n),
			.enable     (en),
			.valid      (v_s5),
			.dividend_hi(v_hi[j]),
			.dividend_lo({ks_s5.mag[j][15:0], 16'd0}),
			.divisor    (ks_s5.rho),
			.side       (v_side[j]),
			.quo_valid  (v_vel[j]),
			.quotient   (v_quo[j]),
			.quo_side   (v_side_out[j])
		);
	end

	// output register
	c2p_pkg::clip_t      vc [3];
	c2p_pkg::clip_t      tc, hc;
	logic                hneg;
	c2p_pkg::prim_word_t res;
	logic                prim_v_q;
	c2p_pkg::prim_word_t prim_q;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			vc[k] = c2p_pkg::clip32(v_side_out[k].neg,
				v_side_out[k].sat ? c2p_pkg::MAG_HUGE : {32'd0, v_quo[k]});
		end
		hneg = t_side_out.sgn && !t_side_out.gzero && (t_side_out.tsat || t_quo != 32'd0);
		tc   = c2p_pkg::clip32(hneg, t_side_out.tsat ? c2p_pkg::MAG_HUGE : {32'd0, t_quo});
		hc   = thermal_q ? t_side_out.th : tc;
		if (t_side_out.zero) begin
			res.vel_x        = '0;
			res.vel_y        = '0;
			res.vel_z        = '0;
			res.heat_value   = '0;
			res.zero_density = 1'b1;
			res.overflow     = 1'b0;
		end else begin
			res.vel_x        = vc[0].val;
			res.vel_y        = vc[1].val;
			res.vel_z        = vc[2].val;
			res.heat_value   = hc.val;
			res.zero_density = 1'b0;
			res.overflow     = vc[0].ov | vc[1].ov | vc[2].ov | hc.ov;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prim_v_q <= 1'b0;
		end else if (en) begin
			prim_v_q <= v_t & (&v_vel);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prim_q <= res;
		end
	end

	assign prim_valid = prim_v_q;
	assign prim       = prim_q;

	a_lanes_agree: assert property (@(posedge clk) disable iff (!arst_n)
		(v_t == v_vel[0]) && (v_t == v_vel[1]) && (v_t == v_vel[2]))
		else $error("divider lanes out of step");

	a_zero_word: assert property (@(posedge clk) disable iff (!arst_n)
		prim_valid && prim.zero_density |->
			!prim.overflow && prim.heat_value == 32'sd0 && prim.vel_x == 32'sd0)
		else $error("zero density word not cleared");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!cell_ready |=> $stable(v_s1) && $stable(v_s5))
		else $error("pipeline moved during stall");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
module testbench;

	localparam int LATENCY   = 98;
	localparam int WDOG_MAX  = 20000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cell_valid = 1'b0;
	logic                cell_ready;
	c2p_pkg::cell_word_t cons = '0;
	logic                prim_valid;
	logic                prim_ready = 1'b0;
	c2p_pkg::prim_word_t prim;
	logic                write_en = 1'b0;
	logic [1:0]          reg_index = c2p_pkg::REG_THERMAL_MODE;
	logic [13:0]         write_data = '0;

	conservative_to_primitive i_dut (
		.clk(clk), .arst_n(arst_n),
		.cell_valid(cell_valid), .cell_ready(cell_ready), .cons(cons),
		.prim_valid(prim_valid), .prim_ready(prim_ready), .prim(prim),
		.write_en(write_en), .reg_index(reg_index), .write_data(write_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	class prim_scoreboard;
		c2p_pkg::prim_word_t pending[$];
		bit                  temp_mode = 1'b0;
		logic [13:0]         gamma = c2p_pkg::GAMMA_RESET;
		int                  errors = 0;

		function logic [31:0] sat32(bit neg, logic [63:0] mag, ref bit ov);
			if (neg) begin
				if (mag > 64'h8000_0000) begin
					ov = 1'b1;
					return 32'h8000_0000;
				end
				return 32'(64'd0 - mag);
			end
			if (mag > 64'h7FFF_FFFF) begin
				ov = 1'b1;
				return 32'h7FFF_FFFF;
			end
			return mag[31:0];
		endfunction

		function c2p_pkg::prim_word_t convert(c2p_pkg::cell_word_t c);
			c2p_pkg::prim_word_t p;
			logic [63:0] rho, sumsq, mag, ke, tmag, a, q, r, gm;
			logic signed [63:0] e, eth, g;
			logic [31:0] mom[3];
			bit ov, neg, tneg, gneg;
			p = '0;
			ov = 1'b0;
			sumsq = '0;
			rho = 64'(c.density);
			if (rho == 64'd0) begin
				p.zero_density = 1'b1;
				return p;
			end
			mom[0] = c.momentum_x;
			mom[1] = c.momentum_y;
			mom[2] = c.momentum_z;
			for (int k = 0; k < 3; k++) begin
				neg = mom[k][31];
				mag = neg ? 64'h1_0000_0000 - 64'(mom[k]) : 64'(mom[k]);
				sumsq += mag * mag;
				mom[k] = sat32(neg, (mag << 16) / rho, ov);
			end
			p.vel_x = mom[0];
			p.vel_y = mom[1];
			p.vel_z = mom[2];
			ke = sumsq / (rho * 64'd2);
			if (ke > 64'h800_0000_0000_0000)
				ke = 64'h800_0000_0000_0000;
			e = 64'(c.total_energy);
			eth = e - $signed(ke);
			tneg = eth < 0;
			tmag = tneg ? 64'(-eth) : 64'(eth);
			if (!temp_mode) begin
				p.heat_value = sat32(tneg, tmag, ov);
			end else begin
				g = $signed(64'(gamma)) - 64'sd4096;
				gneg = g < 0;
				gm = gneg ? 64'(-g) : 64'(g);
				a = tmag << 4;
				q = a / rho;
				r = a % rho;
				if (gm == 64'd0)
					mag = '0;
				else if (q > 64'h1_0000_0000)
					mag = 64'h1_0000_0000;
				else
					mag = q * gm + (r * gm) / rho;
				p.heat_value = sat32(mag != 64'd0 && (tneg != gneg), mag, ov);
			end
			p.overflow = ov;
			return p;
		endfunction

		function void note_cell(c2p_pkg::cell_word_t c);
			pending.push_back(convert(c));
		endfunction

		function void check_prim(c2p_pkg::prim_word_t got);
			c2p_pkg::prim_word_t want;
			if (pending.size() == 0) begin
				$display("%0t unexpected word %h", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.vel_x !== want.vel_x || got.vel_y !== want.vel_y ||
				got.vel_z !== want.vel_z || got.heat_value !== want.heat_value ||
				got.zero_density !== want.zero_density || got.overflow !== want.overflow) begin
				$display("%0t mismatch expected %h actual %h", $time, want, got);
				errors++;
			end
		endfunction
	endclass

	prim_scoreboard board = new();
	bit  hold_rx = 1'b0;
	int  idle_cycles = 0;
	int  n_sent = 0;

	function automatic logic [31:0] rnd_word();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< $urandom_range(0, 20);
			3: return 32'($urandom_range(0, 4000)) - 32'd2000;
			default: return $urandom;
		endcase
	endfunction

	function automatic c2p_pkg::cell_word_t rnd_cell();
		c2p_pkg::cell_word_t c;
		case ($urandom_range(0, 9))
			0: c.density = '0;
			1: c.density = 31'h7FFF_FFFF;
			2: c.density = 31'($urandom_range(1, 16));
			3, 4: c.density = 31'h1_0000 + 31'($urandom_range(0, 'hFFFF)) - 31'h8000;
			default: c.density = 31'($urandom);
		endcase
		c.momentum_x = rnd_word();
		c.momentum_y = rnd_word();
		c.momentum_z = rnd_word();
		c.total_energy = rnd_word();
		return c;
	endfunction

	task automatic send_cell(c2p_pkg::cell_word_t c, int gap);
		if (gap > 0) begin
			cell_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cell_valid <= 1'b1;
		cons <= c;
		do @(posedge clk); while (!cell_ready);
		board.note_cell(c);
		n_sent++;
	endtask

	task automatic write_reg(logic [1:0] idx, logic [13:0] val);
		cell_valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		write_en <= 1'b1;
		reg_index <= idx;
		write_data <= val;
		@(posedge clk);
		write_en <= 1'b0;
		if (idx == c2p_pkg::REG_THERMAL_MODE)
			board.temp_mode = !val[0];
		else
			board.gamma = val;
	endtask

	task automatic run_random(int count, bit fast);
		for (int i = 0; i < count; i++)
			send_cell(rnd_cell(), fast ? 0 : $urandom_range(0, 18));
	endtask

	always @(posedge clk) begin
		if (prim_valid && prim_ready)
			board.check_prim(prim);
		if ((cell_valid && cell_ready) || (prim_valid && prim_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_MAX) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// receiver with random stalls, a long hold-off on request
	initial begin
		int wait_n;
		@(posedge arst_n);
		forever begin
			if (hold_rx) begin
				wait_n = 300;
				hold_rx = 1'b0;
			end else begin
				wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
			end
			if (wait_n != 0) begin
				prim_ready <= 1'b0;
				repeat (wait_n) @(posedge clk);
			end
			prim_ready <= 1'b1;
			do @(posedge clk); while (!prim_valid);
		end
	end

	initial begin
		c2p_pkg::cell_word_t c;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed corners, reset configuration
		c = '0;
		send_cell(c, 0);
		c.density = 31'h1_0000;
		c.momentum_x = 32'sh7FFF_FFFF;
		c.momentum_y = 32'sh8000_0000;
		c.momentum_z = 32'sh0002_0000;
		c.total_energy = 32'sh7FFF_FFFF;
		send_cell(c, 0);
		c.density = 31'h7FFF_FFFF;
		c.total_energy = 32'sh8000_0000;
		send_cell(c, 1);
		c.density = 31'd1;
		c.momentum_x = 32'sd1;
		c.momentum_y = -32'sd1;
		c.momentum_z = 32'sd0;
		c.total_energy = 32'sd0;
		send_cell(c, 0);
		c.density = 31'h2_0000;
		c.momentum_x = 32'sh0001_0000;
		c.momentum_y = 32'sh0;
		c.momentum_z = -32'sh0003_0000;
		c.total_energy = 32'sh0010_0000;
		send_cell(c, 2);
		run_random(390, 0);
		hold_rx = 1'b1;
		run_random(150, 1);
		// temperature mode, several gammas including the extremes
		write_reg(c2p_pkg::REG_THERMAL_MODE, 14'd0);
		for (int i = 0; i < 5; i++)
			send_cell(rnd_cell(), 0);
		write_reg(c2p_pkg::REG_ADIABATIC_INDEX, 14'd4097);
		run_random(120, 0);
		write_reg(c2p_pkg::REG_ADIABATIC_INDEX, 14'd16383);
		run_random(120, 0);
		write_reg(c2p_pkg::REG_ADIABATIC_INDEX, 14'd4096);
		run_random(40, 0);
		write_reg(c2p_pkg::REG_ADIABATIC_INDEX, 14'd0);
		run_random(40, 0);
		write_reg(c2p_pkg::REG_ADIABATIC_INDEX, 14'($urandom_range(4097, 16383)));
		run_random(150, 0);
		write_reg(c2p_pkg::REG_THERMAL_MODE, 14'd1);
		run_random(80, 0);
		cell_valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (board.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
